// ===== hdl/cbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbvs_pkg
// Shared constants and types for the cost-benefit victim selector.
// ----------------------------------------------------------------------------
package cbvs_pkg;

  localparam int BLOCKS_PER_DIE = 4096;
  localparam int BLOCK_SLICES   = 256;

  localparam int BLK_W      = 12;
  localparam int ACT_W      = 13;
  localparam int TICK_W     = 32;
  localparam int INV_W      = 9;
  localparam int WEAR_W     = 16;
  localparam int NUM_W      = TICK_W + INV_W;
  localparam int DEN_W      = INV_W + 1;
  localparam int PROD_W     = NUM_W + DEN_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [ACT_W-1:0]     ACTIVE_NONE      = ACT_W'(4096);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TICK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCK = CFG_IDX_W'(1);

  typedef struct packed {
    logic              eligible;
    logic [BLK_W-1:0]  blk;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [INV_W-1:0]  inv;
    logic [WEAR_W-1:0] wear;
    logic              last;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctrl_t;

endpackage

// ===== hdl/cbvs_front.sv =====
// ----------------------------------------------------------------------------
// cbvs_front
// Accepts descriptors, holds the config registers, numbers the blocks,
// checks eligibility and forms the exact score fraction.
// ----------------------------------------------------------------------------
module cbvs_front
  import cbvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_is_bad,
  input  logic                  in_is_free,
  input  logic [INV_W-1:0]      in_invalid_slices,
  input  logic [WEAR_W-1:0]     in_erase_count,
  input  logic [TICK_W-1:0]     in_update_tick,
  input  logic                  in_last_block,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  logic [TICK_W-1:0] tick_r;
  logic [ACT_W-1:0]  active_r;
  logic [BLK_W-1:0]  blk_cnt_r;
  logic [BLK_W-1:0]  blk_cnt_nxt;

  logic [INV_W-1:0]  inv_sat;
  logic [INV_W-1:0]  valid_cnt;
  logic [TICK_W-1:0] age;
  logic [NUM_W-1:0]  prod;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  assign inv_sat   = (in_invalid_slices > INV_W'(BLOCK_SLICES)) ?
                     INV_W'(BLOCK_SLICES) : in_invalid_slices;
  assign valid_cnt = INV_W'(BLOCK_SLICES) - inv_sat;
  assign age       = tick_r - in_update_tick;
  assign prod      = NUM_W'(age) * NUM_W'(inv_sat);

  always_comb begin
    q_item.eligible = !in_is_bad && !in_is_free && (ACT_W'(blk_cnt_r) != active_r) &&
                      (inv_sat != '0);
    q_item.blk      = blk_cnt_r;
    q_item.num      = (valid_cnt == '0) ? NUM_W'(age) : prod;
    q_item.den      = (valid_cnt == '0) ? DEN_W'(1) : {valid_cnt, 1'b0};
    q_item.inv      = inv_sat;
    q_item.wear     = in_erase_count;
    q_item.last     = in_last_block;
  end

  always_comb begin
    if (in_last_block || (blk_cnt_r == BLK_W'(BLOCKS_PER_DIE - 1))) begin
      blk_cnt_nxt = '0;
    end else begin
      blk_cnt_nxt = blk_cnt_r + BLK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      active_r  <= ACTIVE_NONE;
      blk_cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_CURRENT_TICK: tick_r   <= TICK_W'(cfg_data);
          REG_ACTIVE_BLOCK: active_r <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        blk_cnt_r <= blk_cnt_nxt;
      end
    end
  end

endmodule

// ===== hdl/cbvs_fifo.sv =====
// ----------------------------------------------------------------------------
// cbvs_fifo
// Short register queue of scored descriptors between front and back.
// ----------------------------------------------------------------------------
module cbvs_fifo
  import cbvs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   wr_item,
  input  logic    pop,
  output item_t   rd_item,
  output logic    full,
  output logic    empty
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ===== hdl/cbvs_back.sv =====
// ----------------------------------------------------------------------------
// cbvs_back
// Cross-multiplies each score against the running best, applies the tie
// rules and reports the victim on the last descriptor.
// ----------------------------------------------------------------------------
module cbvs_back
  import cbvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  item_t             q_item,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_victim_found,
  output logic [BLK_W-1:0]  out_victim_block
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_CMP} state_t;

  state_t             state_r;
  item_t              cur_r;
  logic [PROD_W-1:0]  lhs_r;
  logic [PROD_W-1:0]  rhs_r;
  logic               have_best_r;
  logic [BLK_W-1:0]   best_blk_r;
  logic [NUM_W-1:0]   best_num_r;
  logic [DEN_W-1:0]   best_den_r;
  logic [INV_W-1:0]   best_inv_r;
  logic [WEAR_W-1:0]  best_wear_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic [BLK_W-1:0]   out_blk_r;

  logic               take;
  logic               out_free;
  logic               out_load;
  logic               have_best_nxt;
  logic [BLK_W-1:0]   best_blk_nxt;

  assign q_pop            = (state_r == S_IDLE) && !q_empty;
  assign out_valid        = out_valid_r;
  assign out_victim_found = out_found_r;
  assign out_victim_block = out_blk_r;
  assign out_free         = !out_valid_r || out_ready;
  assign out_load         = (state_r == S_CMP) && cur_r.last && out_free;

  always_comb begin
    if (!cur_r.eligible) begin
      take = 1'b0;
    end else if (!have_best_r) begin
      take = 1'b1;
    end else if (lhs_r > rhs_r) begin
      take = 1'b1;
    end else if (lhs_r == rhs_r) begin
      take = (cur_r.inv > best_inv_r) ||
             ((cur_r.inv == best_inv_r) && (cur_r.wear > best_wear_r));
    end else begin
      take = 1'b0;
    end
    have_best_nxt = have_best_r || take;
    best_blk_nxt  = take ? cur_r.blk : best_blk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_best_r <= 1'b0;
      best_blk_r  <= '0;
      best_num_r  <= '0;
      best_den_r  <= DEN_W'(1);
      best_inv_r  <= '0;
      best_wear_r <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_blk_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_found_r <= have_best_nxt;
        out_blk_r   <= have_best_nxt ? best_blk_nxt : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r   <= q_item;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          lhs_r   <= PROD_W'(cur_r.num) * PROD_W'(best_den_r);
          rhs_r   <= PROD_W'(best_num_r) * PROD_W'(cur_r.den);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!cur_r.last) begin
            if (take) begin
              have_best_r <= 1'b1;
              best_blk_r  <= cur_r.blk;
              best_num_r  <= cur_r.num;
              best_den_r  <= cur_r.den;
              best_inv_r  <= cur_r.inv;
              best_wear_r <= cur_r.wear;
            end
            state_r <= S_IDLE;
          end else if (out_free) begin
            have_best_r <= 1'b0;
            best_blk_r  <= '0;
            best_num_r  <= '0;
            best_den_r  <= DEN_W'(1);
            best_inv_r  <= '0;
            best_wear_r <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_clear_best: assert property (@(posedge clk) disable iff (!rst_n)
    !have_best_r |-> (best_num_r == '0) && (best_den_r == DEN_W'(1)))
    else $error("best score not cleared");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_den_r != '0)
    else $error("zero best denominator");

  a_fail_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_blk_r == '0)
    else $error("block index reported without victim");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CMP) && $past(cur_r.last))
    else $error("result not caused by last descriptor");

endmodule

// ===== hdl/cost_benefit_victim_select.sv =====
// ----------------------------------------------------------------------------
// cost_benefit_victim_select
// Cost-benefit garbage-collection victim selection over one die.
//
// Usage: write current_tick (index 0) and active_block (index 1) on the cfg
// channel, then stream one descriptor per block, in block order, on the in_
// channel, the final one with in_last_block set. The block with the highest
// age*invalid/(2*valid) score wins, ties going to more invalid slices, then
// higher erase count, then the earlier block. One transfer on the out_
// channel follows the last descriptor: victim_found and victim_block.
// The back end handles one descriptor at a time (dequeue, cross-multiply,
// compare and update) before it takes the next. The front scores a
// descriptor as it is accepted and queues up to two ahead of the back end.
// After the last descriptor is accepted, it passes through the queue and
// the dequeue, cross-multiply and compare steps; the result is registered.
// Reset clears the scan, sets current_tick to 0 and active_block to none.
// A stalled receiver holds the result; the back end then waits on the next
// last descriptor, and the queue fills before in_ready drops.
// ----------------------------------------------------------------------------
module cost_benefit_victim_select
  import cbvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_is_bad,
  input  logic                  in_is_free,
  input  logic [INV_W-1:0]      in_invalid_slices,
  input  logic [WEAR_W-1:0]     in_erase_count,
  input  logic [TICK_W-1:0]     in_update_tick,
  input  logic                  in_last_block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_victim_found,
  output logic [BLK_W-1:0]      out_victim_block
);

  item_t   push_item;
  item_t   head_item;
  q_ctrl_t q_ctrl;

  cbvs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_is_bad         (in_is_bad),
    .in_is_free        (in_is_free),
    .in_invalid_slices (in_invalid_slices),
    .in_erase_count    (in_erase_count),
    .in_update_tick    (in_update_tick),
    .in_last_block     (in_last_block),
    .q_full            (q_ctrl.full),
    .q_push            (q_ctrl.push),
    .q_item            (push_item)
  );

  cbvs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_ctrl.push),
    .wr_item (push_item),
    .pop     (q_ctrl.pop),
    .rd_item (head_item),
    .full    (q_ctrl.full),
    .empty   (q_ctrl.empty)
  );

  cbvs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (head_item),
    .q_empty          (q_ctrl.empty),
    .q_pop            (q_ctrl.pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_victim_found (out_victim_found),
    .out_victim_block (out_victim_block)
  );

endmodule
